FILE: hdl/rbow_pkg.sv
// Shared types and constants for the scalar to rainbow color pipeline.
// No dependencies; imported by rbow_div and scalar_to_rainbow_color_top.
`timescale 1ns / 1ps

package rbow_pkg;

    // Fraction bits of the incoming sample and of the normalized scalar.
    localparam int SAMPLE_FRAC_BITS = 16;
    localparam int NORM_BITS        = 16;

    // 1.0 in Q.16, the mid gray level and six times the blue hue 0.666.
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] HALF_Q16  = 17'd32768;
    localparam logic [17:0] HUE6_SPAN = 18'd261882;

    // The sample value -1.0 marks a point that is shown in mid gray.
    localparam logic [31:0] GRAY_MARKER = ~((32'd1 << SAMPLE_FRAC_BITS) - 32'd1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_SATURATION = 2'd2,
        CFG_BRIGHTNESS = 2'd3
    } t_cfg_idx;

    // How the normalized scalar of an item is formed.
    typedef enum logic [1:0] {
        CLS_DIV  = 2'd0,   // quotient of the divider
        CLS_ZERO = 2'd1,   // sample at or below the low end
        CLS_FULL = 2'd2,   // sample at or above the high end
        CLS_GRAY = 2'd3    // gray marker or empty range
    } t_class;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic   vld;
        t_class cls;
    } t_tag;

endpackage

FILE: hdl/scalar_to_rainbow_color_top.sv
// Rainbow pseudocolor map: one signed Q16.16 scalar in, one RGB color out.
// The result strobe passes the input, classify, divider, hue, ramp, level and output registers.
// Throughput: one transaction per clock; busy never rises and nothing stalls.
// The depth is set by the 16-stage quotient pipeline of the normalizer.
// Reset (synchronous, active low) sets the configuration and derived registers to
// their defaults and empties the pipeline; the receiver cannot stall the results.
`timescale 1ns / 1ps

module scalar_to_rainbow_color_top import rbow_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Sample channel.
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic signed [31:0]      i_sample,
    // Result channel: one strobe per color.
    output logic                    o_valid,
    output logic [CHANNEL_BITS-1:0] o_red,
    output logic [CHANNEL_BITS-1:0] o_green,
    output logic [CHANNEL_BITS-1:0] o_blue,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;
    localparam int                      PROD_W   = 17 + CHANNEL_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the derived values
    // below are registered from these and may change while items are in flight.
    // ------------------------------------------------------------------
    logic [31:0] r_low;
    logic [31:0] r_high;
    logic [8:0]  r_sat;
    logic [8:0]  r_bright;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= 32'd0;
            r_high   <= 32'd6553600;
            r_sat    <= 9'd256;
            r_bright <= 9'd256;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RANGE_LOW: begin
                    r_low <= i_cfg_data;
                end
                CFG_RANGE_HIGH: begin
                    r_high <= i_cfg_data;
                end
                CFG_SATURATION: begin
                    r_sat <= i_cfg_data[8:0];
                end
                CFG_BRIGHTNESS: begin
                    r_bright <= i_cfg_data[8:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // Derived constants: range width, empty-range flag, chroma c = V * S and
    // the offset m = V * 256 - c that is added to every channel.
    logic               r_empty;
    logic [31:0]        r_den;
    logic [17:0]        r_chroma;
    logic signed [18:0] r_offset;
    logic [17:0]        n_chroma;
    logic signed [18:0] n_offset;

    assign n_chroma = r_sat * r_bright;
    assign n_offset = $signed({2'b00, r_bright, 8'h00}) - $signed({1'b0, n_chroma});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty  <= 1'b0;
            r_den    <= 32'd6553600;
            r_chroma <= 18'd65536;
            r_offset <= '0;
        end else begin
            r_empty  <= ($signed(r_high) <= $signed(r_low));
            r_den    <= r_high - r_low;
            r_chroma <= n_chroma;
            r_offset <= n_offset;
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic        r_in_vld;
    logic [31:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start & ~o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= i_sample;
    end

    // ------------------------------------------------------------------
    // Classify: distance from the low end, and whether the normalized value
    // is a plain 0, a plain 1.0, mid gray, or needs the divider.
    // ------------------------------------------------------------------
    logic signed [32:0] w_num;
    logic               w_at_low;
    logic               w_at_high;
    t_class             n_cls;
    t_tag               r_cls_tag;
    logic [31:0]        r_num;

    assign w_num     = $signed({r_sample[31], r_sample}) - $signed({r_low[31], r_low});
    assign w_at_low  = w_num[32] || (w_num == 33'sd0);
    assign w_at_high = (w_num[31:0] >= r_den);

    always_comb begin
        if (r_sample == GRAY_MARKER || r_empty) begin
            n_cls = CLS_GRAY;
        end else if (w_at_low) begin
            n_cls = CLS_ZERO;
        end else if (w_at_high) begin
            n_cls = CLS_FULL;
        end else begin
            n_cls = CLS_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_tag <= '0;
        end else begin
            r_cls_tag <= '{vld: r_in_vld, cls: n_cls};
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= w_num[31:0];
    end

    // ------------------------------------------------------------------
    // Normalize: a = floor(num * 2^16 / den), one quotient bit per stage.
    // ------------------------------------------------------------------
    t_tag                 w_div_tag;
    logic [NORM_BITS-1:0] w_quo;

    rbow_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_cls_tag),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_tag   (w_div_tag),
        .o_quo   (w_quo)
    );

    // ------------------------------------------------------------------
    // Hue: hue6 = floor(HUE6_SPAN * (1.0 - a)), so a = 0 is blue and
    // a = 1.0 is red. Its integer part is the sector.
    // ------------------------------------------------------------------
    logic [16:0] w_norm;
    logic [16:0] w_inv;
    logic [34:0] w_hue_prod;
    t_tag        r_hue_tag;
    logic [17:0] r_hue6;

    always_comb begin
        case (w_div_tag.cls)
            CLS_ZERO: w_norm = 17'd0;
            CLS_FULL: w_norm = ONE_Q16;
            default:  w_norm = {1'b0, w_quo};
        endcase
    end

    assign w_inv      = ONE_Q16 - w_norm;
    assign w_hue_prod = 35'(HUE6_SPAN) * 35'(w_inv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_tag <= '0;
        end else begin
            r_hue_tag <= w_div_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue6 <= w_hue_prod[33:16];
    end

    // ------------------------------------------------------------------
    // Ramp: x = c * f in even sectors and c * (1.0 - f) in odd ones.
    // ------------------------------------------------------------------
    logic [16:0] w_ramp;
    logic [34:0] w_x_prod;
    t_tag        r_x_tag;
    logic [2:0]  r_sector;
    logic [17:0] r_x;

    assign w_ramp   = r_hue6[16] ? (ONE_Q16 - {1'b0, r_hue6[15:0]}) : {1'b0, r_hue6[15:0]};
    assign w_x_prod = 35'(r_chroma) * 35'(w_ramp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_tag <= '0;
        end else begin
            r_x_tag <= r_hue_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sector <= {1'b0, r_hue6[17:16]};
        r_x      <= w_x_prod[33:16];
    end

    // ------------------------------------------------------------------
    // Sector select, offset and clamp to [0, 1.0]. Gray items take 0.5.
    // ------------------------------------------------------------------
    logic [17:0] w_sel_r;
    logic [17:0] w_sel_g;
    logic [17:0] w_sel_b;
    logic        r_lvl_vld;
    logic [16:0] r_lvl_r;
    logic [16:0] r_lvl_g;
    logic [16:0] r_lvl_b;

    function automatic logic [16:0] clamp_level(input logic [17:0] sel,
                                                input logic signed [18:0] ofs);
        logic signed [19:0] sum;
        begin
            sum = $signed({2'b00, sel}) + $signed({ofs[18], ofs});
            if (sum[19]) begin
                clamp_level = 17'd0;
            end else if (sum > $signed({3'b000, ONE_Q16})) begin
                clamp_level = ONE_Q16;
            end else begin
                clamp_level = sum[16:0];
            end
        end
    endfunction

    always_comb begin
        case (r_sector)
            3'd0: begin
                w_sel_r = r_chroma; w_sel_g = r_x;      w_sel_b = '0;
            end
            3'd1: begin
                w_sel_r = r_x;      w_sel_g = r_chroma; w_sel_b = '0;
            end
            3'd2: begin
                w_sel_r = '0;       w_sel_g = r_chroma; w_sel_b = r_x;
            end
            3'd3: begin
                w_sel_r = '0;       w_sel_g = r_x;      w_sel_b = r_chroma;
            end
            3'd4: begin
                w_sel_r = r_x;      w_sel_g = '0;       w_sel_b = r_chroma;
            end
            default: begin
                w_sel_r = r_chroma; w_sel_g = '0;       w_sel_b = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld <= 1'b0;
        end else begin
            r_lvl_vld <= r_x_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_x_tag.cls == CLS_GRAY) begin
            r_lvl_r <= HALF_Q16;
            r_lvl_g <= HALF_Q16;
            r_lvl_b <= HALF_Q16;
        end else begin
            r_lvl_r <= clamp_level(w_sel_r, r_offset);
            r_lvl_g <= clamp_level(w_sel_g, r_offset);
            r_lvl_b <= clamp_level(w_sel_b, r_offset);
        end
    end

    // ------------------------------------------------------------------
    // Output: scale each level to the channel width, rounding half up.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] w_prod_r;
    logic [PROD_W-1:0] w_prod_g;
    logic [PROD_W-1:0] w_prod_b;
    logic              r_out_vld;
    logic [CHANNEL_BITS-1:0] r_red;
    logic [CHANNEL_BITS-1:0] r_green;
    logic [CHANNEL_BITS-1:0] r_blue;

    assign w_prod_r = PROD_W'(r_lvl_r) * PROD_W'(CHAN_MAX) + PROD_W'(HALF_Q16);
    assign w_prod_g = PROD_W'(r_lvl_g) * PROD_W'(CHAN_MAX) + PROD_W'(HALF_Q16);
    assign w_prod_b = PROD_W'(r_lvl_b) * PROD_W'(CHAN_MAX) + PROD_W'(HALF_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_lvl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= w_prod_r[16 +: CHANNEL_BITS];
        r_green <= w_prod_g[16 +: CHANNEL_BITS];
        r_blue  <= w_prod_b[16 +: CHANNEL_BITS];
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

FILE: hdl/rbow_div.sv
// Pipelined restoring divider: NORM_BITS quotient bits, one per stage.
// Depends on rbow_pkg for the item tag type and NORM_BITS.
`timescale 1ns / 1ps

module rbow_div import rbow_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tag                 i_tag,
    input  logic [31:0]          i_num,
    input  logic [31:0]          i_den,
    output t_tag                 o_tag,
    output logic [NORM_BITS-1:0] o_quo
);

    // The numerator is below the divisor, so every remainder fits in 32 bits
    // and the quotient of num * 2^NORM_BITS / den fits in NORM_BITS bits.
    t_tag                 r_tag [NORM_BITS];
    logic [31:0]          r_rem [NORM_BITS];
    logic [NORM_BITS-1:0] r_quo [NORM_BITS];

    for (genvar k = 0; k < NORM_BITS; k++) begin : g_step
        t_tag                 w_tag_in;
        logic [31:0]          w_rem_in;
        logic [NORM_BITS-1:0] w_quo_in;
        logic [32:0]          w_shift;
        logic [32:0]          w_diff;
        logic                 w_take;

        if (k == 0) begin : g_first
            assign w_tag_in = i_tag;
            assign w_rem_in = i_num;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_tag_in = r_tag[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_shift = {w_rem_in, 1'b0};
        assign w_diff  = w_shift - {1'b0, i_den};
        assign w_take  = (w_shift >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_take ? w_diff[31:0] : w_shift[31:0];
            r_quo[k] <= {w_quo_in[NORM_BITS-2:0], w_take};
        end
    end

    assign o_tag = r_tag[NORM_BITS-1];
    assign o_quo = r_quo[NORM_BITS-1];

endmodule
